// ----- hw/rtl/drsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the debug record stream parser.
package drsp_pkg;

	// record type codes (low byte of a header word)
	localparam logic [7:0] REC_FILE_NAME = 8'd1;
	localparam logic [7:0] REC_FUNC_NAME = 8'd2;
	localparam logic [7:0] REC_LOCATION  = 8'd3;

	// name bytes carried in the header word, and per continuation word
	localparam logic [23:0] HDR_NAME_BYTES  = 24'd4;
	localparam logic [23:0] WORD_NAME_BYTES = 24'd8;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;

	typedef enum logic [1:0] {
		KIND_FILE_CHAR = 2'd0,
		KIND_FUNC_CHAR = 2'd1,
		KIND_LOCATION  = 2'd2,
		KIND_ERROR     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NAME   = 2'd1,
		PH_LOC2   = 2'd2,
		PH_LOC3   = 2'd3
	} phase_t;

	// what a word asks the emit sequencer to produce
	typedef enum logic [2:0] {
		EM_NONE  = 3'd0,
		EM_CHARS = 3'd1,
		EM_EMPTY = 3'd2,
		EM_LOC   = 3'd3,
		EM_ERR   = 3'd4
	} emit_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// parser state carried between words
	typedef struct packed {
		phase_t      phase;
		logic        halted;
		logic        is_func;
		logic [23:0] left;
		logic [23:0] file_idx;
		logic [31:0] line;
		logic [23:0] col;
		logic [7:0]  count;
		logic [31:0] func_idx;
	} parse_t;

	// emit plan for one accepted word
	typedef struct packed {
		emit_t       mode;
		logic [63:0] data;
		logic [3:0]  nchars;
		logic        ends;
		logic [1:0]  err;
	} plan_t;

endpackage

// ----- hw/rtl/drsp_decode.sv -----
`timescale 1ns / 1ps
// Word decoder: next parser state and emit plan for one section word.
module drsp_decode (
	input  logic [63:0]           word,
	input  logic                  end_of_section,
	input  drsp_pkg::parse_t      cur,
	output drsp_pkg::parse_t      nxt,
	output drsp_pkg::plan_t       plan
);

	logic [7:0]  rec_type;
	logic [23:0] rec_len;
	logic        trunc_err;
	logic        unknown_err;

	assign rec_type = word[7:0];
	assign rec_len  = word[31:8];

	always_comb begin
		nxt         = cur;
		plan.mode   = drsp_pkg::EM_NONE;
		plan.data   = word;
		plan.nchars = 4'd0;
		plan.ends   = 1'b0;
		plan.err    = drsp_pkg::ERR_NONE;
		trunc_err   = 1'b0;
		unknown_err = 1'b0;

		if (!cur.halted) begin
			unique case (cur.phase)
				drsp_pkg::PH_HEADER: begin
					if (rec_type == drsp_pkg::REC_FILE_NAME ||
							rec_type == drsp_pkg::REC_FUNC_NAME) begin
						nxt.is_func = (rec_type == drsp_pkg::REC_FUNC_NAME);
						plan.data   = {32'd0, word[63:32]};
						if (rec_len == 24'd0) begin
							plan.mode = drsp_pkg::EM_EMPTY;
						end else if (rec_len <= drsp_pkg::HDR_NAME_BYTES) begin
							plan.mode   = drsp_pkg::EM_CHARS;
							plan.nchars = rec_len[3:0];
							plan.ends   = 1'b1;
						end else if (end_of_section) begin
							trunc_err = 1'b1;
						end else begin
							plan.mode   = drsp_pkg::EM_CHARS;
							plan.nchars = drsp_pkg::HDR_NAME_BYTES[3:0];
							nxt.left    = rec_len - drsp_pkg::HDR_NAME_BYTES;
							nxt.phase   = drsp_pkg::PH_NAME;
						end
					end else if (rec_type == drsp_pkg::REC_LOCATION) begin
						nxt.file_idx = word[31:8];
						nxt.line     = word[63:32];
						if (end_of_section) begin
							trunc_err = 1'b1;
						end else begin
							nxt.phase = drsp_pkg::PH_LOC2;
						end
					end else begin
						unknown_err = 1'b1;
					end
				end
				drsp_pkg::PH_NAME: begin
					if (cur.left <= drsp_pkg::WORD_NAME_BYTES) begin
						plan.mode   = drsp_pkg::EM_CHARS;
						plan.nchars = cur.left[3:0];
						plan.ends   = 1'b1;
						nxt.left    = 24'd0;
						nxt.phase   = drsp_pkg::PH_HEADER;
					end else if (end_of_section) begin
						trunc_err = 1'b1;
					end else begin
						plan.mode   = drsp_pkg::EM_CHARS;
						plan.nchars = drsp_pkg::WORD_NAME_BYTES[3:0];
						nxt.left    = cur.left - drsp_pkg::WORD_NAME_BYTES;
					end
				end
				drsp_pkg::PH_LOC2: begin
					nxt.col      = word[23:0];
					nxt.count    = word[31:24];
					nxt.func_idx = word[63:32];
					if (end_of_section) begin
						trunc_err = 1'b1;
					end else begin
						nxt.phase = drsp_pkg::PH_LOC3;
					end
				end
				drsp_pkg::PH_LOC3: begin
					plan.mode = drsp_pkg::EM_LOC;
					nxt.phase = drsp_pkg::PH_HEADER;
				end
				default: begin
					nxt.phase = drsp_pkg::PH_HEADER;
				end
			endcase

			if (trunc_err || unknown_err) begin
				plan.mode  = drsp_pkg::EM_ERR;
				plan.err   = trunc_err ? drsp_pkg::ERR_TRUNCATED : drsp_pkg::ERR_UNKNOWN;
				nxt.halted = 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/debug_record_stream_parser_core.sv -----
`timescale 1ns / 1ps
// Top level of the debug record stream parser: handshakes and emit sequencer.
//
// Usage:
//   Word channel (word, end_of_section, word_valid/word_ready) takes the debug
//   section one 64-bit little-endian word per request; end_of_section marks the
//   last word. Result channel (result_valid/result_ready) returns decoded
//   requests: name characters, one per result, location records and errors.
//   Timing: a word is taken while the sequencer is idle, then a shared byte
//   shifter and down counter emit its results one per cycle unless stalled,
//   up to 8 for a full name word and none for a word with no result.
//   word_ready is high only while the sequencer is idle.
//   The emit state entered after a word is taken registers its first result.
//   Reset: parser returns to expecting a header word, halt flag clears, no
//   result is pending.
//   Stall: while result_ready is low the output register holds its result and
//   the sequencer waits; nothing is dropped.
//   After an error result the parser halts: words are still taken but give no
//   result until reset.
module debug_record_stream_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] word,
	input  logic        end_of_section,
	input  logic        word_valid,
	output logic        word_ready,
	output logic [1:0]  kind,
	output logic [7:0]  name_char,
	output logic        char_present,
	output logic        name_end,
	output logic [23:0] file_number,
	output logic [31:0] line_number,
	output logic [23:0] column_number,
	output logic [7:0]  instr_count,
	output logic [31:0] func_number,
	output logic [63:0] code_address,
	output logic [1:0]  error_code,
	output logic        last,
	output logic        result_valid,
	input  logic        result_ready
);

	drsp_pkg::state_t state_q, state_d;
	drsp_pkg::parse_t parse_q, parse_d, parse_nxt;
	drsp_pkg::plan_t  plan;

	// emit sequencer datapath
	drsp_pkg::emit_t  mode_q, mode_d;
	logic [63:0]      data_q, data_d;     // shifts one byte per emitted char
	logic [3:0]       cnt_q, cnt_d;       // chars left in this word
	logic             ends_q, ends_d;
	logic [1:0]       err_q, err_d;

	// output register
	logic             out_valid_q, out_valid_d;
	drsp_pkg::kind_t  kind_q, kind_d;
	logic [7:0]       char_q, char_d;
	logic             present_q, present_d;
	logic             name_end_q, name_end_d;
	logic [23:0]      file_q, file_d;
	logic [31:0]      line_q, line_d;
	logic [23:0]      col_q, col_d;
	logic [7:0]       count_q, count_d;
	logic [31:0]      func_q, func_d;
	logic [63:0]      addr_q, addr_d;
	logic [1:0]       ecode_q, ecode_d;
	logic             last_q, last_d;

	logic             slot_free;
	logic             accept;

	drsp_decode u_decode (
		.word           (word),
		.end_of_section (end_of_section),
		.cur            (parse_q),
		.nxt            (parse_nxt),
		.plan           (plan)
	);

	assign slot_free = !out_valid_q || result_ready;
	assign accept    = word_valid && word_ready;

	always_comb begin
		state_d     = state_q;
		parse_d     = parse_q;
		mode_d      = mode_q;
		data_d      = data_q;
		cnt_d       = cnt_q;
		ends_d      = ends_q;
		err_d       = err_q;
		word_ready  = 1'b0;

		out_valid_d = out_valid_q && !result_ready;
		kind_d      = kind_q;
		char_d      = char_q;
		present_d   = present_q;
		name_end_d  = name_end_q;
		file_d      = file_q;
		line_d      = line_q;
		col_d       = col_q;
		count_d     = count_q;
		func_d      = func_q;
		addr_d      = addr_q;
		ecode_d     = ecode_q;
		last_d      = last_q;

		unique case (state_q)
			drsp_pkg::ST_IDLE: begin
				word_ready = 1'b1;
				if (word_valid) begin
					parse_d = parse_nxt;
					mode_d  = plan.mode;
					data_d  = plan.data;
					cnt_d   = plan.nchars;
					ends_d  = plan.ends;
					err_d   = plan.err;
					if (plan.mode != drsp_pkg::EM_NONE) begin
						state_d = drsp_pkg::ST_EMIT;
					end
				end
			end
			drsp_pkg::ST_EMIT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					kind_d      = parse_q.is_func ? drsp_pkg::KIND_FUNC_CHAR
					                              : drsp_pkg::KIND_FILE_CHAR;
					char_d      = 8'd0;
					present_d   = 1'b0;
					name_end_d  = 1'b0;
					file_d      = 24'd0;
					line_d      = 32'd0;
					col_d       = 24'd0;
					count_d     = 8'd0;
					func_d      = 32'd0;
					addr_d      = 64'd0;
					ecode_d     = drsp_pkg::ERR_NONE;
					last_d      = 1'b1;
					state_d     = drsp_pkg::ST_IDLE;
					unique case (mode_q)
						drsp_pkg::EM_CHARS: begin
							char_d     = data_q[7:0];
							present_d  = 1'b1;
							last_d     = (cnt_q == 4'd1);
							name_end_d = ends_q && (cnt_q == 4'd1);
							data_d     = {8'd0, data_q[63:8]};
							cnt_d      = cnt_q - 4'd1;
							if (cnt_q != 4'd1) begin
								state_d = drsp_pkg::ST_EMIT;
							end
						end
						drsp_pkg::EM_EMPTY: begin
							name_end_d = 1'b1;
						end
						drsp_pkg::EM_LOC: begin
							kind_d = drsp_pkg::KIND_LOCATION;
							file_d = parse_q.file_idx;
							line_d = parse_q.line;
							col_d  = parse_q.col;
							count_d = parse_q.count;
							func_d = parse_q.func_idx;
							addr_d = data_q;
						end
						drsp_pkg::EM_ERR: begin
							kind_d  = drsp_pkg::KIND_ERROR;
							ecode_d = err_q;
						end
						default: begin
							out_valid_d = out_valid_q && !result_ready;
						end
					endcase
				end
			end
			default: begin
				state_d = drsp_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drsp_pkg::ST_IDLE;
			parse_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			parse_q     <= parse_d;
			out_valid_q <= out_valid_d;
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		data_q     <= data_d;
		cnt_q      <= cnt_d;
		ends_q     <= ends_d;
		err_q      <= err_d;
		kind_q     <= kind_d;
		char_q     <= char_d;
		present_q  <= present_d;
		name_end_q <= name_end_d;
		file_q     <= file_d;
		line_q     <= line_d;
		col_q      <= col_d;
		count_q    <= count_d;
		func_q     <= func_d;
		addr_q     <= addr_d;
		ecode_q    <= ecode_d;
		last_q     <= last_d;
	end

	assign result_valid   = out_valid_q;
	assign kind           = kind_q;
	assign name_char      = char_q;
	assign char_present   = present_q;
	assign name_end       = name_end_q;
	assign file_number    = file_q;
	assign line_number    = line_q;
	assign column_number  = col_q;
	assign instr_count    = count_q;
	assign func_number    = func_q;
	assign code_address   = addr_q;
	assign error_code     = ecode_q;
	assign last           = last_q;

	// char sequencer never runs with an empty or oversized count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == drsp_pkg::ST_EMIT && mode_q == drsp_pkg::EM_CHARS
		|-> cnt_q != 4'd0 && cnt_q <= 4'd8)
		else $error("char count out of range");

	// halt is sticky until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		parse_q.halted |=> parse_q.halted)
		else $error("halt flag dropped");

	// end of name only on a file or function name result that also closes its word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && name_end_q
		|-> last_q && (kind_q == drsp_pkg::KIND_FILE_CHAR ||
		               kind_q == drsp_pkg::KIND_FUNC_CHAR))
		else $error("name end on wrong result");

	// an error result implies the parser is halted
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == drsp_pkg::KIND_ERROR |-> parse_q.halted)
		else $error("error result without halt");

	// nothing is taken while results of the previous word are still being emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !(state_q == drsp_pkg::ST_EMIT && accept))
		else $error("word taken during emit");

endmodule
